### rtl/core/lz_token_bitstream_encoder_defines.svh
// Assertion macros used by the encoder back end.
`ifndef LZ_TOKEN_BITSTREAM_ENCODER_DEFINES_SVH
`define LZ_TOKEN_BITSTREAM_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS
`define LZENC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lzenc assertion failed");
`define LZENC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lzenc assertion failed");
`else
`define LZENC_ASSERT(lbl, prop)
`define LZENC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### rtl/core/lzenc_pkg.sv
// Types and constants shared by the encoder modules.
`default_nettype none
package lzenc_pkg;

  typedef enum logic [1:0] {
    REQ_TOKEN = 2'd0,
    REQ_LIT   = 2'd1,
    REQ_END   = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    PH_FLAG  = 3'd0,
    PH_G1    = 3'd1,
    PH_BYTE  = 3'd2,
    PH_G2    = 3'd3,
    PH_FLUSH = 3'd4,
    PH_BAD   = 3'd5
  } phase_e;

  localparam int unsigned NumPhases = 6;

  typedef struct packed {
    logic [3:0]  n;
    logic [15:0] v;
    logic        skip;
  } gamma_t;

  typedef struct packed {
    logic       flag_en;
    logic       flag_val;
    gamma_t     g1;
    logic       byte_en;
    logic [7:0] byte_val;
    logic       g2_en;
    gamma_t     g2;
    logic       flush;
    logic       bad;
  } cmd_t;

  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  data;
    logic        done;
    logic        bad;
  } res_t;

endpackage
`default_nettype wire

### rtl/core/lzenc_front.sv
// Front end: accepts requests, tracks the offset state and builds commands.
`default_nettype none
module lzenc_front #(
  parameter int unsigned LEN_BITS = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire  [15:0]         cfg_wdata_i,
  input  wire                 s_valid_i,
  output logic                s_ready_o,
  input  wire  [39:0]         s_data_i,
  input  wire  [1:0]          s_user_i,
  input  wire                 fifo_full_i,
  output logic                push_o,
  output lzenc_pkg::cmd_t     cmd_o
);

  logic [15:0] init_off_q, init_off_d;
  logic [15:0] last_off_q, last_off_d;
  logic        first_q, first_d;

  logic [15:0]         off;
  logic [LEN_BITS-1:0] len, len_m1;
  logic [LEN_BITS+15:0] len_x, len_m1_x;
  logic [15:0]         off_m1, off_hi;
  logic                accept;

  function automatic lzenc_pkg::gamma_t make_gamma(input logic [15:0] v, input logic skip);
    lzenc_pkg::gamma_t g;
    logic [3:0]  n;
    logic [15:0] w;
    n = '0;
    for (int i = 1; i < 16; i++) begin
      if (v[i]) n = 4'(i);
    end
    w = v & ~(16'd1 << n);
    // Long codes carry the low byte first.
    if (n >= 4'd8) g.v = (w >> 8) | ((w & 16'h00ff) << (n - 4'd8));
    else g.v = v;
    g.n = n;
    g.skip = skip;
    return g;
  endfunction

  assign off      = s_data_i[15:0];
  assign len      = s_data_i[16 +: LEN_BITS];
  assign len_m1   = len - LEN_BITS'(1);
  assign len_x    = {16'b0, len};
  assign len_m1_x = {16'b0, len_m1};
  assign off_m1   = off - 16'd1;
  assign off_hi   = (off_m1 >> 7) + 16'd1;

  assign s_ready_o = !fifo_full_i;
  assign accept    = s_valid_i && s_ready_o;

  always_comb begin
    cmd_o      = '0;
    push_o     = 1'b0;
    last_off_d = last_off_q;
    first_d    = first_q;
    init_off_d = init_off_q;
    unique case (s_user_i)
      lzenc_pkg::REQ_TOKEN: begin
        push_o = accept;
        if (len == '0) begin
          cmd_o.bad = 1'b1;
        end else if (off == 16'd0) begin
          cmd_o.flag_en = !first_q;
          cmd_o.g1      = make_gamma(len_x[15:0], 1'b0);
          if (accept) first_d = 1'b0;
        end else if (off == last_off_q) begin
          cmd_o.flag_en = 1'b1;
          cmd_o.g1      = make_gamma(len_x[15:0], 1'b0);
        end else begin
          cmd_o.flag_en  = 1'b1;
          cmd_o.flag_val = 1'b1;
          cmd_o.g1       = make_gamma(off_hi, 1'b0);
          cmd_o.byte_en  = 1'b1;
          cmd_o.byte_val = {off_m1[6:0], (len == LEN_BITS'(2))};
          cmd_o.g2_en    = 1'b1;
          cmd_o.g2       = make_gamma(len_m1_x[15:0], 1'b1);
          if (accept) last_off_d = off;
        end
      end
      lzenc_pkg::REQ_LIT: begin
        push_o         = accept;
        cmd_o.byte_en  = 1'b1;
        cmd_o.byte_val = s_data_i[39:32];
      end
      lzenc_pkg::REQ_END: begin
        push_o         = accept;
        cmd_o.flag_en  = 1'b1;
        cmd_o.flag_val = 1'b1;
        cmd_o.g1       = make_gamma(16'd256, 1'b0);
        cmd_o.flush    = 1'b1;
        if (accept) begin
          last_off_d = init_off_q;
          first_d    = 1'b1;
        end
      end
      default: push_o = 1'b0;
    endcase
    if (cfg_we_i) begin
      init_off_d = cfg_wdata_i;
      last_off_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_off_q <= 16'd1;
      last_off_q <= 16'd1;
      first_q    <= 1'b1;
    end else begin
      init_off_q <= init_off_d;
      last_off_q <= last_off_d;
      first_q    <= first_d;
    end
  end

endmodule
`default_nettype wire

### rtl/core/lzenc_cmd_fifo.sv
// Two-entry command queue between the front and back ends.
`default_nettype none
module lzenc_cmd_fifo (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  lzenc_pkg::cmd_t  cmd_i,
  output logic             full_o,
  input  wire              pop_i,
  output logic             valid_o,
  output lzenc_pkg::cmd_t  cmd_o
);

  lzenc_pkg::cmd_t mem_q [2];
  logic            wr_q, rd_q;
  logic [1:0]      cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule
`default_nettype wire

### rtl/core/lzenc_back.sv
// Back end: bit packer, write sequencer and output staging.
`default_nettype none
`include "lz_token_bitstream_encoder_defines.svh"
module lzenc_back #(
  parameter int unsigned ADDR_BITS = 16
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              head_valid_i,
  input  lzenc_pkg::cmd_t  head_i,
  output logic             pop_o,
  output logic             m_valid_o,
  input  wire              m_ready_i,
  output logic [23:0]      m_data_o,
  output logic             m_last_o,
  output logic [1:0]       m_user_o
);

  lzenc_pkg::phase_e phase_q, phase_d, cur_phase;
  logic [4:0]        k_q, k_d, cur_k;
  logic              started_q, started_d;

  logic [ADDR_BITS-1:0] wp_q, wp_d, bb_addr_q, bb_addr_d, baddr;
  logic [7:0]           bb_val_q, bb_val_d, base;
  logic [3:0]           left_q, left_d, left;
  logic                 open;

  lzenc_pkg::res_t p_q, o_q, res;
  logic            p_valid_q, p_final_q, o_valid_q, o_last_q;

  logic [5:0]        en;
  logic [3:0]        first_nf, next_nf;
  lzenc_pkg::gamma_t g;
  logic              gbit, phase_end, done_now, gen, op_fire, o_free, p_move;
  logic [3:0]        gidx;
  logic [ADDR_BITS+15:0] addr_x;

  function automatic logic [3:0] first_from(input logic [5:0] e, input logic [2:0] from);
    logic       found;
    logic [2:0] ph;
    found = 1'b0;
    ph    = '0;
    for (int p = 0; p < lzenc_pkg::NumPhases; p++) begin
      if (!found && 3'(p) >= from && e[p]) begin
        found = 1'b1;
        ph    = 3'(p);
      end
    end
    return {found, ph};
  endfunction

  function automatic logic [4:0] kstart(input logic [2:0] ph, input logic skip);
    return (ph == lzenc_pkg::PH_G2 && skip) ? 5'd1 : 5'd0;
  endfunction

  // A skipped gamma of zero has no bits at all.
  always_comb begin
    en = '0;
    en[lzenc_pkg::PH_FLAG]  = head_i.flag_en;
    en[lzenc_pkg::PH_G1]    = head_i.flag_en || !head_i.byte_en;
    en[lzenc_pkg::PH_BYTE]  = head_i.byte_en;
    en[lzenc_pkg::PH_G2]    = head_i.g2_en && !(head_i.g2.skip && head_i.g2.n == 4'd0);
    en[lzenc_pkg::PH_FLUSH] = head_i.flush;
    en[lzenc_pkg::PH_BAD]   = head_i.bad;
    if (head_i.bad) en[lzenc_pkg::PH_G1] = 1'b0;
  end

  assign first_nf  = first_from(en, lzenc_pkg::PH_FLAG);
  assign cur_phase = started_q ? phase_q : lzenc_pkg::phase_e'(first_nf[2:0]);
  assign cur_k     = started_q ? k_q : kstart(first_nf[2:0], head_i.g2.skip);
  assign next_nf   = first_from(en, cur_phase + 3'd1);
  assign g         = (cur_phase == lzenc_pkg::PH_G2) ? head_i.g2 : head_i.g1;
  assign gidx      = g.n - 4'd1 - cur_k[4:1];

  // Gamma bit order: a zero before each data bit, a one at the end; a skipped gamma drops its first zero.
  always_comb begin
    if (cur_k == {g.n, 1'b0}) gbit = 1'b1;
    else if (cur_k[0]) gbit = g.v[gidx];
    else gbit = 1'b0;
  end

  assign open  = left_q == 4'd0;
  assign left  = open ? 4'd8 : left_q;
  assign base  = open ? 8'd0 : bb_val_q;
  assign baddr = open ? wp_q : bb_addr_q;

  always_comb begin
    gen       = 1'b0;
    res       = '0;
    phase_end = 1'b1;
    wp_d      = wp_q;
    bb_addr_d = bb_addr_q;
    bb_val_d  = bb_val_q;
    left_d    = left_q;
    addr_x    = '0;
    unique case (cur_phase)
      lzenc_pkg::PH_FLAG, lzenc_pkg::PH_G1, lzenc_pkg::PH_G2: begin
        if (cur_phase != lzenc_pkg::PH_FLAG) phase_end = cur_k == {g.n, 1'b0};
        left_d    = left - 4'd1;
        bb_val_d  = base | (8'((cur_phase == lzenc_pkg::PH_FLAG) ? head_i.flag_val : gbit)
                            << left_d[2:0]);
        bb_addr_d = baddr;
        wp_d      = open ? wp_q + ADDR_BITS'(1) : wp_q;
        gen       = left == 4'd1;
        addr_x    = {16'b0, baddr};
        res.data  = bb_val_d;
      end
      lzenc_pkg::PH_BYTE: begin
        gen      = 1'b1;
        addr_x   = {16'b0, wp_q};
        res.data = head_i.byte_val;
        wp_d     = wp_q + ADDR_BITS'(1);
      end
      lzenc_pkg::PH_FLUSH: begin
        gen       = left_q != 4'd0;
        addr_x    = {16'b0, bb_addr_q};
        res.data  = bb_val_q;
        wp_d      = '0;
        bb_addr_d = '0;
        bb_val_d  = '0;
        left_d    = '0;
      end
      lzenc_pkg::PH_BAD: begin
        gen     = 1'b1;
        addr_x  = {16'b0, wp_q};
        res.bad = 1'b1;
      end
      default: gen = 1'b0;
    endcase
    res.addr = addr_x[15:0];
    res.done = head_i.flush;
  end

  assign done_now = phase_end && !next_nf[3];
  assign o_free   = !o_valid_q || m_ready_i;
  assign op_fire  = head_valid_i && (o_free || !(p_valid_q && (p_final_q || gen || done_now)));
  assign p_move   = p_valid_q && o_free && (p_final_q || (head_valid_i && (gen || done_now)));
  assign pop_o    = op_fire && done_now;

  // Sequencer next state.
  always_comb begin
    phase_d   = phase_q;
    k_d       = k_q;
    started_d = started_q;
    if (op_fire) begin
      if (!phase_end) begin
        phase_d   = cur_phase;
        k_d       = cur_k + 5'd1;
        started_d = 1'b1;
      end else if (done_now) begin
        started_d = 1'b0;
      end else begin
        phase_d   = lzenc_pkg::phase_e'(next_nf[2:0]);
        k_d       = kstart(next_nf[2:0], head_i.g2.skip);
        started_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= lzenc_pkg::PH_FLAG;
      k_q       <= '0;
      started_q <= 1'b0;
      wp_q      <= '0;
      bb_addr_q <= '0;
      bb_val_q  <= '0;
      left_q    <= '0;
      p_valid_q <= 1'b0;
      p_final_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      k_q       <= k_d;
      started_q <= started_d;
      if (op_fire) begin
        wp_q      <= wp_d;
        bb_addr_q <= bb_addr_d;
        bb_val_q  <= bb_val_d;
        left_q    <= left_d;
      end
      if (op_fire && gen) begin
        p_valid_q <= 1'b1;
        p_final_q <= done_now;
      end else if (p_move) begin
        p_valid_q <= 1'b0;
        p_final_q <= 1'b0;
      end
      if (p_move) o_valid_q <= 1'b1;
      else if (m_ready_i) o_valid_q <= 1'b0;
    end
  end

  // The held result learns whether it is the last one of its request.
  always_ff @(posedge clk_i) begin
    if (op_fire && gen) p_q <= res;
    if (p_move) begin
      o_q      <= p_q;
      o_last_q <= p_final_q || (done_now && !gen);
    end
  end

  assign m_valid_o = o_valid_q;
  assign m_data_o  = {o_q.data, o_q.addr};
  assign m_last_o  = o_last_q;
  assign m_user_o  = {o_q.bad, o_q.done && o_last_q};

  `LZENC_ASSERT(a_left_range, left_q <= 4'd8)
  `LZENC_ASSERT(a_final_valid, p_final_q |-> p_valid_q)
  `LZENC_ASSERT(a_pop_head, pop_o |-> head_valid_i)
  `LZENC_ASSERT(a_bad_last, (m_valid_o && m_user_o[1]) |-> m_last_o)
  `LZENC_ASSERT_NEXT(a_move_out, p_move, m_valid_o)

endmodule
`default_nettype wire

### rtl/core/lz_token_bitstream_encoder.sv
// An accepted request passes the command queue and the pending and output result registers.
// Throughput: the back end packs one flag or gamma bit, or one byte, per cycle while the
// output is not stalled; the end request also flushes a partly filled bit byte.
// Reset: asynchronous and active low; the initial offset returns to 1 and the queue empties.
`default_nettype none
module lz_token_bitstream_encoder #(
  parameter int unsigned ADDR_BITS = 16,
  parameter int unsigned LEN_BITS  = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [15:0] cfg_wdata_i,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [39:0] s_axis_tdata_i,   // tok_offset, tok_length, lit_byte
  input  wire  [1:0]  s_axis_tuser_i,   // req_type
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // out_index, out_byte
  output logic        m_axis_tlast_o,
  output logic [1:0]  m_axis_tuser_o    // stream_done, bad_token
);

  logic            push, full, pop, head_valid;
  lzenc_pkg::cmd_t push_cmd, head_cmd;

  lzenc_front #(.LEN_BITS(LEN_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .s_data_i    (s_axis_tdata_i),
    .s_user_i    (s_axis_tuser_i),
    .fifo_full_i (full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  lzenc_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .cmd_o   (head_cmd)
  );

  lzenc_back #(.ADDR_BITS(ADDR_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_cmd),
    .pop_o        (pop),
    .m_valid_o    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready_i),
    .m_data_o     (m_axis_tdata_o),
    .m_last_o     (m_axis_tlast_o),
    .m_user_o     (m_axis_tuser_o)
  );

endmodule
`default_nettype wire

### verif/tb_lz_token_bitstream_encoder.sv
// Self-checking testbench for the LZ token bitstream encoder.
`timescale 1ns / 1ps
module tb_lz_token_bitstream_encoder;

  typedef struct {
    logic [15:0] addr;
    logic [7:0]  data;
    logic        last;
    logic        done;
    logic        bad;
  } wr_t;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] off;
    logic [15:0] len;
    logic [7:0]  lit;
    logic        has_exp;
    logic [15:0] e_addr;
    logic [7:0]  e_data;
  } row_t;

  localparam int unsigned CycleLimit = 400000;
  localparam logic [1:0]  ReqUnused  = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic [1:0]  m_axis_tuser_o;

  lz_token_bitstream_encoder dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tlast_o,
    .m_axis_tuser_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state.
  logic [15:0] init_off, last_off, wptr, bb_addr;
  logic [7:0]  bb_val;
  logic [3:0]  bb_left;
  logic        first_lit;
  wr_t         pending_writes[$];
  wr_t         item_writes[$];
  int          errors = 0;
  int          cycles = 0;
  int          writes_seen = 0;
  int          tokens_sent = 0;
  bit          calm = 1'b0;
  bit          in_busy = 1'b0;

  function automatic void enc_reset_state();
    last_off = init_off;
    first_lit = 1'b1;
    wptr = '0;
    bb_addr = '0;
    bb_val = '0;
    bb_left = '0;
  endfunction

  function automatic void enc_write(logic [15:0] a, logic [7:0] d);
    wr_t w;
    w.addr = a; w.data = d; w.last = 0; w.done = 0; w.bad = 0;
    item_writes.push_back(w);
  endfunction

  function automatic void enc_bit(bit b);
    if (bb_left == 0) begin
      bb_addr = wptr;
      wptr = wptr + 16'd1;
      bb_val = '0;
      bb_left = 4'd8;
    end
    if (b) bb_val[bb_left - 1] = 1'b1;
    bb_left = bb_left - 4'd1;
    if (bb_left == 0) enc_write(bb_addr, bb_val);
  endfunction

  function automatic void enc_gamma(logic [16:0] v, bit skip);
    logic [16:0] top;
    logic [16:0] m;
    int nb;
    top = 17'd1;
    nb = 0;
    while ((top << 1) <= v) begin
      top = top << 1;
      nb++;
    end
    if (nb >= 8) begin
      v = v & (17'h0ffff ^ top);
      v = (v >> 8) | ((v & 17'hff) << (nb - 8));
    end
    for (m = top >> 1; m != 0; m = m >> 1) begin
      if (!skip) enc_bit(1'b0);
      skip = 1'b0;
      enc_bit((v & m) != 0);
    end
    if (!skip) enc_bit(1'b1);
  endfunction

  // Computes the writes one accepted request causes and queues them.
  function automatic void predict_writes(logic [1:0] kind, logic [15:0] off,
                                         logic [15:0] len, logic [7:0] lit);
    wr_t w;
    logic [15:0] om1;
    bit done;
    done = 1'b0;
    item_writes.delete();
    if (kind == lzenc_pkg::REQ_TOKEN) begin
      if (len == 0) begin
        w.addr = wptr; w.data = 0; w.last = 1; w.done = 0; w.bad = 1;
        pending_writes.push_back(w);
        return;
      end
      if (off == 0) begin
        if (!first_lit) enc_bit(1'b0);
        enc_gamma({1'b0, len}, 1'b0);
        first_lit = 1'b0;
      end else if (off == last_off) begin
        enc_bit(1'b0);
        enc_gamma({1'b0, len}, 1'b0);
      end else begin
        om1 = off - 16'd1;
        enc_bit(1'b1);
        enc_gamma({1'b0, om1 >> 7} + 17'd1, 1'b0);
        enc_write(wptr, {om1[6:0], len == 16'd2});
        wptr = wptr + 16'd1;
        enc_gamma({1'b0, len} - 17'd1, 1'b1);
        last_off = off;
      end
    end else if (kind == lzenc_pkg::REQ_LIT) begin
      enc_write(wptr, lit);
      wptr = wptr + 16'd1;
    end else if (kind == lzenc_pkg::REQ_END) begin
      enc_bit(1'b1);
      enc_gamma(17'd256, 1'b0);
      if (bb_left != 0) enc_write(bb_addr, bb_val);
      done = 1'b1;
      enc_reset_state();
    end
    if (item_writes.size() > 0) begin
      item_writes[$].last = 1'b1;
      item_writes[$].done = done;
    end
    foreach (item_writes[i]) pending_writes.push_back(item_writes[i]);
  endfunction

  // Output side: random stalls and comparison with the oldest expectation.
  always @(posedge clk_i) begin
    wr_t w;
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        writes_seen <= writes_seen + 1;
        if (pending_writes.size() == 0) begin
          $error("unexpected write addr=%h data=%h", m_axis_tdata_o[15:0],
                 m_axis_tdata_o[23:16]);
          errors++;
        end else begin
          w = pending_writes.pop_front();
          if (m_axis_tdata_o[15:0] !== w.addr) begin
            $error("out_index exp %h got %h", w.addr, m_axis_tdata_o[15:0]); errors++;
          end
          if (m_axis_tdata_o[23:16] !== w.data) begin
            $error("out_byte exp %h got %h", w.data, m_axis_tdata_o[23:16]); errors++;
          end
          if (m_axis_tlast_o !== w.last) begin
            $error("last_write exp %b got %b", w.last, m_axis_tlast_o); errors++;
          end
          if (m_axis_tuser_o[0] !== w.done) begin
            $error("stream_done exp %b got %b", w.done, m_axis_tuser_o[0]); errors++;
          end
          if (m_axis_tuser_o[1] !== w.bad) begin
            $error("bad_token exp %b got %b", w.bad, m_axis_tuser_o[1]); errors++;
          end
        end
      end
      m_axis_tready_i <= calm || ($urandom_range(99) >= 28);
    end
    if (cycles > CycleLimit) begin
      $display("tb_lz_token_bitstream_encoder: FAIL");
      $finish;
    end
  end

  // Presents one request with random idle gaps and waits for acceptance.
  task automatic send_req(logic [1:0] kind, logic [15:0] off, logic [15:0] len,
                          logic [7:0] lit);
    while (!calm && $urandom_range(99) < 28) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= kind;
    s_axis_tdata_i <= {lit, len, off};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_writes(kind, off, len, lit);
    if (kind == lzenc_pkg::REQ_TOKEN) tokens_sent++;
  endtask

  task automatic drain_and_config(logic [15:0] value);
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    init_off = value;
    last_off = value;
  endtask

  // Random stream: literal runs with their bytes, repeats, new matches, zero-length tokens, unused kinds, an end.
  task automatic random_stream(int n_items, output int used);
    int k;
    int r;
    int run;
    logic [15:0] off, len;
    used = 0;
    while (used < n_items) begin
      r = $urandom_range(99);
      if (r < 35) begin
        run = $urandom_range(1, 6);
        send_req(lzenc_pkg::REQ_TOKEN, 16'd0, run[15:0], 8'h00);
        used++;
        for (k = 0; k < run; k++) begin
          send_req(lzenc_pkg::REQ_LIT, 16'($urandom), 16'($urandom), 8'($urandom));
          used++;
        end
      end else if (r < 50) begin
        send_req(lzenc_pkg::REQ_TOKEN, last_off, 16'($urandom_range(1, 40)),
                 8'($urandom));
        used++;
      end else if (r < 85) begin
        case ($urandom_range(3))
          0: off = 16'($urandom_range(1, 128));
          1: off = 16'($urandom_range(1, 2000));
          default: off = 16'($urandom);
        endcase
        case ($urandom_range(4))
          0: len = 16'd2;
          1: len = 16'd1;
          2: len = 16'($urandom);
          default: len = 16'($urandom_range(3, 300));
        endcase
        send_req(lzenc_pkg::REQ_TOKEN, off, len, 8'($urandom));
        used++;
      end else if (r < 92) begin
        send_req(lzenc_pkg::REQ_TOKEN, 16'($urandom), 16'd0, 8'($urandom));
        used++;
      end else if (r < 96) begin
        send_req(ReqUnused, 16'($urandom), 16'($urandom), 8'($urandom));
      end else begin
        send_req(lzenc_pkg::REQ_LIT, 16'($urandom), 16'($urandom), 8'($urandom));
        used++;
      end
    end
    send_req(lzenc_pkg::REQ_END, 16'($urandom), 16'($urandom), 8'($urandom));
    used++;
  endtask

  row_t dir_rows[$];
  wr_t  got_w;

  function automatic row_t mk(logic [1:0] kind, logic [15:0] off, logic [15:0] len,
                              logic [7:0] lit, bit he, logic [15:0] ea, logic [7:0] ed);
    row_t r;
    r.kind = kind; r.off = off; r.len = len; r.lit = lit;
    r.has_exp = he; r.e_addr = ea; r.e_data = ed;
    return r;
  endfunction

  initial begin
    int total;
    int used;
    int i;
    init_off = 16'd1;
    enc_reset_state();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; rows with a typed value check the single write they cause.
    dir_rows.push_back(mk(lzenc_pkg::REQ_TOKEN, 16'h0, 16'h0, 8'h0, 1, 16'h0, 8'h00));
    dir_rows.push_back(mk(lzenc_pkg::REQ_LIT, 16'h0, 16'h0, 8'hff, 1, 16'h0, 8'hff));
    dir_rows.push_back(mk(lzenc_pkg::REQ_LIT, 16'hffff, 16'hffff, 8'h00, 1, 16'h1, 8'h00));
    dir_rows.push_back(mk(lzenc_pkg::REQ_TOKEN, 16'h0, 16'h1, 8'h0, 0, 0, 0));
    dir_rows.push_back(mk(lzenc_pkg::REQ_LIT, 16'h0, 16'h0, 8'h5a, 0, 0, 0));
    dir_rows.push_back(mk(lzenc_pkg::REQ_TOKEN, 16'h1, 16'h3, 8'h0, 0, 0, 0));
    dir_rows.push_back(mk(lzenc_pkg::REQ_TOKEN, 16'h80, 16'h2, 8'h0, 0, 0, 0));
    dir_rows.push_back(mk(lzenc_pkg::REQ_TOKEN, 16'h80, 16'h9, 8'h0, 0, 0, 0));
    dir_rows.push_back(mk(lzenc_pkg::REQ_TOKEN, 16'hffff, 16'hffff, 8'h0, 0, 0, 0));
    dir_rows.push_back(mk(lzenc_pkg::REQ_TOKEN, 16'h81, 16'h1, 8'h0, 0, 0, 0));
    dir_rows.push_back(mk(lzenc_pkg::REQ_TOKEN, 16'h0, 16'hffff, 8'h0, 0, 0, 0));
    dir_rows.push_back(mk(lzenc_pkg::REQ_TOKEN, 16'h0, 16'h100, 8'h0, 0, 0, 0));
    dir_rows.push_back(mk(ReqUnused, 16'hffff, 16'hffff, 8'hff, 0, 0, 0));
    dir_rows.push_back(mk(lzenc_pkg::REQ_TOKEN, 16'h2, 16'h0, 8'h0, 0, 0, 0));
    dir_rows.push_back(mk(lzenc_pkg::REQ_TOKEN, 16'h2, 16'h80, 8'h0, 0, 0, 0));
    dir_rows.push_back(mk(lzenc_pkg::REQ_END, 16'h0, 16'h0, 8'h0, 0, 0, 0));
    dir_rows.push_back(mk(lzenc_pkg::REQ_END, 16'h0, 16'h0, 8'h0, 0, 0, 0));
    total = 0;
    for (i = 0; i < dir_rows.size(); i++) begin
      send_req(dir_rows[i].kind, dir_rows[i].off, dir_rows[i].len, dir_rows[i].lit);
      if (dir_rows[i].has_exp) begin
        got_w = pending_writes[$];
        if (got_w.addr !== dir_rows[i].e_addr || got_w.data !== dir_rows[i].e_data) begin
          $error("directed row %0d: addr exp %h got %h, byte exp %h got %h", i,
                 dir_rows[i].e_addr, got_w.addr, dir_rows[i].e_data, got_w.data);
          errors++;
        end
      end
      total++;
    end

    // Random streams under several initial offsets, extremes included.
    drain_and_config(16'hffff);
    random_stream(60, used); total += used;
    drain_and_config(16'd1);
    random_stream(60, used); total += used;
    drain_and_config(16'd300);
    calm = 1'b1;
    random_stream(80, used); total += used;
    calm = 1'b0;
    drain_and_config(16'd129);
    random_stream(60, used); total += used;
    // An empty stream: only the end request.
    random_stream(0, used); total += used;
    drain_and_config(16'd7);
    random_stream(140, used); total += used;

    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Covered %0d requests (%0d tokens) and %0d writes over five offsets.",
             total, tokens_sent, writes_seen);
    if (errors == 0 && pending_writes.size() == 0) begin
      $display("tb_lz_token_bitstream_encoder: PASS");
    end else begin
      $display("tb_lz_token_bitstream_encoder: FAIL");
    end
    $finish;
  end
endmodule

### files.f
+incdir+rtl/core
rtl/core/lzenc_pkg.sv
rtl/core/lzenc_front.sv
rtl/core/lzenc_cmd_fifo.sv
rtl/core/lzenc_back.sv
rtl/core/lz_token_bitstream_encoder.sv
verif/tb_lz_token_bitstream_encoder.sv
